// ===== src/xcfd_pkg.sv =====
package xcfd_pkg;

   localparam logic [7:0] SOF_BYTE = 8'hFE;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_FX_HI   = 3'd1,
      PH_FX_LO   = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CHECK   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_DATA   = 3'd1,
      EV_GOOD   = 3'd2,
      EV_BAD    = 3'd3,
      EV_REJECT = 3'd4
   } event_type;

   typedef struct packed {
      event_type   event_res;
      logic [15:0] function_code;
      logic [7:0]  payload_length;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic        last_frame_valid;
   } result_type;

endpackage

// ===== src/xcfd_in_stage.sv =====
module xcfd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign in_ready   = !valid_ff || advance;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !advance);
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

endmodule

// ===== src/xcfd_parser.sv =====
module xcfd_parser #(
   parameter int LENGTH_LIMIT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output xcfd_pkg::result_type result
);

   localparam int IDX_W = (LENGTH_LIMIT > 2) ? $clog2(LENGTH_LIMIT) : 1;
   localparam logic [16:0] LIMIT_VAL = 17'(LENGTH_LIMIT);

   xcfd_pkg::phase_type phase_ff, phase_in;
   logic [15:0]      function_ff, function_in;
   logic [15:0]      length_ff, length_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       xor_ff, xor_in;
   logic             valid_ff, valid_in;

   logic [15:0]      length_full;
   logic [IDX_W-1:0] index_next;
   logic [15:0]      index_wide;
   logic [15:0]      index_next_wide;

   assign length_full     = {length_ff[15:8], rx_byte};
   assign index_next      = index_ff + 1'b1;
   assign index_wide      = 16'(index_ff);
   assign index_next_wide = 16'(index_next);

   always_comb begin
      phase_in    = phase_ff;
      function_in = function_ff;
      length_in   = length_ff;
      index_in    = index_ff;
      xor_in      = xor_ff;
      valid_in    = valid_ff;
      unique case (phase_ff)
         xcfd_pkg::PH_HUNT: begin
            if (rx_byte == xcfd_pkg::SOF_BYTE) begin
               xor_in   = xcfd_pkg::SOF_BYTE;
               phase_in = xcfd_pkg::PH_FX_HI;
            end
         end
         xcfd_pkg::PH_FX_HI: begin
            function_in = {rx_byte, 8'h00};
            xor_in      = xor_ff ^ rx_byte;
            phase_in    = xcfd_pkg::PH_FX_LO;
         end
         xcfd_pkg::PH_FX_LO: begin
            function_in = {function_ff[15:8], rx_byte};
            xor_in      = xor_ff ^ rx_byte;
            phase_in    = xcfd_pkg::PH_LEN_HI;
         end
         xcfd_pkg::PH_LEN_HI: begin
            length_in = {rx_byte, 8'h00};
            xor_in    = xor_ff ^ rx_byte;
            phase_in  = xcfd_pkg::PH_LEN_LO;
         end
         xcfd_pkg::PH_LEN_LO: begin
            length_in = length_full;
            xor_in    = xor_ff ^ rx_byte;
            if (length_full == 16'd0) begin
               phase_in = xcfd_pkg::PH_CHECK;
            end else if ({1'b0, length_full} >= LIMIT_VAL) begin
               phase_in = xcfd_pkg::PH_HUNT;
            end else begin
               index_in = '0;
               phase_in = xcfd_pkg::PH_PAYLOAD;
            end
         end
         xcfd_pkg::PH_PAYLOAD: begin
            xor_in   = xor_ff ^ rx_byte;
            index_in = index_next;
            if (index_next_wide >= length_ff) begin
               phase_in = xcfd_pkg::PH_CHECK;
            end
         end
         xcfd_pkg::PH_CHECK: begin
            valid_in = (xor_ff == rx_byte);
            phase_in = xcfd_pkg::PH_HUNT;
         end
         default: begin
            phase_in = xcfd_pkg::PH_HUNT;
         end
      endcase
   end

   always_comb begin
      result.event_res        = xcfd_pkg::EV_NONE;
      result.function_code    = function_in;
      result.payload_length   = length_in[7:0];
      result.payload_byte     = 8'h00;
      result.payload_index    = 8'h00;
      result.last_frame_valid = valid_in;
      unique case (phase_ff)
         xcfd_pkg::PH_LEN_LO: begin
            if (length_full != 16'd0 && {1'b0, length_full} >= LIMIT_VAL) begin
               result.event_res = xcfd_pkg::EV_REJECT;
            end
         end
         xcfd_pkg::PH_PAYLOAD: begin
            result.event_res     = xcfd_pkg::EV_DATA;
            result.payload_byte  = rx_byte;
            result.payload_index = index_wide[7:0];
         end
         xcfd_pkg::PH_CHECK: begin
            result.event_res = (xor_ff == rx_byte) ? xcfd_pkg::EV_GOOD : xcfd_pkg::EV_BAD;
         end
         default: begin
            result.event_res = xcfd_pkg::EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= xcfd_pkg::PH_HUNT;
         function_ff <= '0;
         length_ff   <= '0;
         index_ff    <= '0;
         xor_ff      <= '0;
         valid_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         function_ff <= function_in;
         length_ff   <= length_in;
         index_ff    <= index_in;
         xor_ff      <= xor_in;
         valid_ff    <= valid_in;
      end
   end

endmodule

// ===== src/xcfd_out_stage.sv =====
module xcfd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  xcfd_pkg::result_type load_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output xcfd_pkg::result_type out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   xcfd_pkg::result_type data_ff;

   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// ===== src/xor_checksum_frame_decoder.sv =====
// Deframes a byte stream of the form start byte 0xFE, 16-bit function code, 16-bit length,
// payload and one XOR checksum byte, and returns exactly one result word for every byte
// word taken in. Payload bytes come out with their index, and the checksum byte gives a
// good or bad verdict; a length at or above LENGTH_LIMIT is rejected and the decoder goes
// back to hunting for the start byte. One byte is taken every clock cycle while the result
// side is not stalled; each byte passes an input register, the parser logic and an output
// register, which holds its result word until the result side is ready to take it.
module xor_checksum_frame_decoder #(
   parameter int LENGTH_LIMIT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // function_code[15:0], payload_length[23:16], payload_byte[31:24],
   // payload_index[39:32], last_frame_valid[40], zero fill [47:41].
   output logic [47:0] rsp_tdata,
   output logic [2:0]  rsp_tuser   // event_res[2:0]
);

   logic                 held_valid;
   logic [7:0]           held_byte;
   logic                 advance;
   xcfd_pkg::result_type parse_result;
   xcfd_pkg::result_type out_result;

   assign advance = held_valid && (!rsp_tvalid || rsp_tready);

   xcfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   xcfd_parser #(
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (held_byte),
      .result  (parse_result)
   );

   xcfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (parse_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {7'b0, out_result.last_frame_valid, out_result.payload_index,
                       out_result.payload_byte, out_result.payload_length,
                       out_result.function_code};
   assign rsp_tuser = out_result.event_res;

`ifndef NO_ASSERTIONS
   a_stall_blocks_parser: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !advance)
      else $error("parser advanced while a result word was stalled");

   a_full_input_moves: assert property (@(posedge clock) disable iff (reset)
      (req_tready && held_valid) |-> advance)
      else $error("input taken while the held byte could not move on");

   a_good_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == xcfd_pkg::EV_GOOD) |-> rsp_tdata[40])
      else $error("good frame reported without the valid flag");

   a_bad_clears_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == xcfd_pkg::EV_BAD) |-> !rsp_tdata[40])
      else $error("bad frame reported with the valid flag set");
`endif

endmodule
